### design/hbs_pkg.sv
package hbs_pkg;

  // Coordinate width: a 16-bit centre plus brush and smoothing offsets.
  localparam int CW    = 18;
  // Width of the effective map size (up to 4096).
  localparam int EW    = 13;
  // Signed brush offset; the radius register is 6 bits wide.
  localparam int RADW  = 7;
  localparam int D2W   = 13;
  localparam int R2W   = 12;
  localparam int RFW   = 21;
  localparam int NUMW  = 44;
  localparam int DENW  = 29;
  localparam int WW    = 17;

  localparam logic [30:0] XQ_SCALE  = 31'd2097152000; // 32000 * 65536
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  localparam logic [2:0] MODE_RAISE   = 3'd0;
  localparam logic [2:0] MODE_LOWER   = 3'd1;
  localparam logic [2:0] MODE_SMOOTH  = 3'd2;
  localparam logic [2:0] MODE_FLATTEN = 3'd3;
  localparam logic [2:0] MODE_NONE    = 3'd4;

  localparam logic [2:0] CFG_RADIUS   = 3'd0;
  localparam logic [2:0] CFG_STRENGTH = 3'd1;
  localparam logic [2:0] CFG_FALLOFF  = 3'd2;
  localparam logic [2:0] CFG_MODE     = 3'd3;
  localparam logic [2:0] CFG_WIDTH    = 3'd4;
  localparam logic [2:0] CFG_HEIGHT   = 3'd5;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_BRUSH = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_RW, OP_BR_INIT, OP_DEN1, OP_DEN2, OP_CHK, OP_NUM,
    OP_DIVW, OP_EXP1, OP_EXP2, OP_EXP3, OP_RDH, OP_CAPH, OP_NB_INIT, OP_NB,
    OP_NB_ACC, OP_DIVA, OP_DIFF, OP_MUL1, OP_MUL2, OP_WB, OP_ADV, OP_FIN
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_RW, S_BR_INIT, S_DEN1, S_DEN2, S_CHK, S_TEST, S_NUM,
    S_DIVW, S_WAITW, S_EXP1, S_EXP2, S_EXP3, S_RDH, S_CAPH, S_NB_INIT, S_NB,
    S_NB_ACC, S_DIVA, S_WAITA, S_DIFF, S_MUL1, S_MUL2, S_WB, S_ADV, S_FIN
  } state_e;

  typedef struct packed {
    logic [5:0]    radius;
    logic [8:0]    strength;
    logic [8:0]    falloff;
    logic [2:0]    mode;
    logic [EW-1:0] eff_w;
    logic [EW-1:0] eff_h;
  } cfg_t;

  typedef struct packed {
    op_e  op;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       skip;
    logic       at_last;
    logic       nb_last;
    logic       div_done;
    logic       smooth;
    logic       out_full;
  } stat_t;

  // 2^(-n/16) in Q16
  function automatic logic [16:0] pow2_frac(input logic [4:0] n);
    logic [16:0] v;
    case (n)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

  function automatic logic in_map(input logic signed [CW-1:0] x,
                                  input logic signed [CW-1:0] y,
                                  input logic [EW-1:0] w,
                                  input logic [EW-1:0] h);
    logic xin;
    logic yin;
    xin = !x[CW-1] && ({1'b0, x[CW-2:0]} < CW'(w));
    yin = !y[CW-1] && ({1'b0, y[CW-2:0]} < CW'(h));
    return xin && yin;
  endfunction

endpackage

### design/hbs_div.sv
module hbs_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [hbs_pkg::NUMW-1:0]  dividend_i,
  input  logic [hbs_pkg::DENW-1:0]  divisor_i,
  output logic                      done_o,
  output logic [hbs_pkg::NUMW-1:0]  quot_o
);
  import hbs_pkg::*;

  localparam int CNW = $clog2(NUMW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CNW-1:0]  cnt_q;
  logic [NUMW-1:0] quot_q;
  logic [DENW-1:0] rem_q;
  logic [DENW-1:0] dvs_q;
  logic [DENW:0]   rem_sh;
  logic            fit;

  // one quotient bit per cycle, restoring
  assign rem_sh = {rem_q, quot_q[NUMW-1]};
  assign fit    = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNW'(NUMW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[NUMW-2:0], fit};
      rem_q  <= fit ? DENW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DENW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### design/hbs_ctrl.sv
module hbs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  hbs_pkg::stat_t stat_i,
  output hbs_pkg::cmd_t  cmd_o
);
  import hbs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (in_valid_i) state_d = S_DISP;
      S_DISP: begin
        case (stat_i.func)
          FUNC_WRITE, FUNC_READ: state_d = S_RW;
          FUNC_BRUSH:            state_d = S_BR_INIT;
          default:               state_d = S_FIN;
        endcase
      end
      S_RW:      state_d = S_FIN;
      S_BR_INIT: state_d = S_DEN1;
      S_DEN1:    state_d = S_DEN2;
      S_DEN2:    state_d = S_CHK;
      S_CHK:     state_d = S_TEST;
      S_TEST: begin
        if (!stat_i.skip)        state_d = S_NUM;
        else if (stat_i.at_last) state_d = S_FIN;
        else                     state_d = S_ADV;
      end
      S_NUM:     state_d = S_DIVW;
      S_DIVW:    state_d = S_WAITW;
      S_WAITW:   if (stat_i.div_done) state_d = S_EXP1;
      S_EXP1:    state_d = S_EXP2;
      S_EXP2:    state_d = S_EXP3;
      S_EXP3:    state_d = S_RDH;
      S_RDH:     state_d = S_CAPH;
      S_CAPH:    state_d = stat_i.smooth ? S_NB_INIT : S_DIFF;
      S_NB_INIT: state_d = S_NB;
      S_NB:      if (stat_i.nb_last) state_d = S_NB_ACC;
      S_NB_ACC:  state_d = S_DIVA;
      S_DIVA:    state_d = S_WAITA;
      S_WAITA:   if (stat_i.div_done) state_d = S_DIFF;
      S_DIFF:    state_d = S_MUL1;
      S_MUL1:    state_d = S_MUL2;
      S_MUL2:    state_d = S_WB;
      S_WB:      state_d = stat_i.at_last ? S_FIN : S_ADV;
      S_ADV:     state_d = S_CHK;
      S_FIN:     if (!stat_i.out_full) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.in_ready = 1'b0;
    cmd_o.op       = OP_NONE;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      S_RW:      cmd_o.op = OP_RW;
      S_BR_INIT: cmd_o.op = OP_BR_INIT;
      S_DEN1:    cmd_o.op = OP_DEN1;
      S_DEN2:    cmd_o.op = OP_DEN2;
      S_CHK:     cmd_o.op = OP_CHK;
      S_NUM:     cmd_o.op = OP_NUM;
      S_DIVW:    cmd_o.op = OP_DIVW;
      S_EXP1:    cmd_o.op = OP_EXP1;
      S_EXP2:    cmd_o.op = OP_EXP2;
      S_EXP3:    cmd_o.op = OP_EXP3;
      S_RDH:     cmd_o.op = OP_RDH;
      S_CAPH:    cmd_o.op = OP_CAPH;
      S_NB_INIT: cmd_o.op = OP_NB_INIT;
      S_NB:      cmd_o.op = OP_NB;
      S_NB_ACC:  cmd_o.op = OP_NB_ACC;
      S_DIVA:    cmd_o.op = OP_DIVA;
      S_DIFF:    cmd_o.op = OP_DIFF;
      S_MUL1:    cmd_o.op = OP_MUL1;
      S_MUL2:    cmd_o.op = OP_MUL2;
      S_WB:      cmd_o.op = OP_WB;
      S_ADV:     cmd_o.op = OP_ADV;
      S_FIN:     if (!stat_i.out_full) cmd_o.op = OP_FIN;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

endmodule

### design/hbs_datapath.sv
module hbs_datapath #(
  parameter int MAX_WIDTH   = 512,
  parameter int MAX_HEIGHT  = 512,
  parameter int MAX_RADIUS  = 50,
  parameter int SMOOTH_HALF = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hbs_pkg::cmd_t      cmd_i,
  input  hbs_pkg::cfg_t      cfg_i,
  input  logic [1:0]         func_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [7:0]         height_in_i,
  input  logic               out_ready_i,
  output hbs_pkg::stat_t     stat_o,
  output logic               out_valid_o,
  output logic [7:0]         height_out_o,
  output logic               out_of_map_o
);
  import hbs_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int NBN   = (2 * SMOOTH_HALF + 1) * (2 * SMOOTH_HALF + 1);
  localparam int CNTW  = $clog2(NBN + 1);
  localparam int SUMW  = CNTW + 8;
  localparam logic signed [3:0] SH = 4'(SMOOTH_HALF);

  op_e op;
  assign op = cmd_i.op;

  // item
  logic [1:0]         func_q;
  logic signed [15:0] cx_q, cy_q;
  logic [7:0]         hin_q;
  logic               item_in;

  // brush walk
  logic signed [RADW-1:0] r_q, i_q, j_q;
  logic [R2W-1:0]         r2_q;
  logic [RFW-1:0]         rf_q;
  logic [DENW-1:0]        den_q;
  logic [D2W-1:0]         d2_q;
  logic signed [CW-1:0]   px_q, py_q;
  logic [NUMW-1:0]        num_q;
  logic signed [13:0]     ii_c, jj_c;
  logic [RADW-1:0]        r_eff;

  // weight
  logic        big_q;
  logic [20:0] y_q;
  logic [4:0]  k_q;
  logic [16:0] tn_q;
  logic [11:0] ip_q;
  logic [WW-1:0] w_q;
  logic [36:0] yprod_c;
  logic [16:0] tn_c, tn1_c, m_c;
  logic [11:0] dlt_c;
  logic [23:0] iprod_c;

  // smoothing window
  logic [7:0]            h_q;
  logic signed [3:0]     di_q, dj_q;
  logic                  pend_q;
  logic [SUMW-1:0]       sum_q;
  logic [CNTW-1:0]       cnt_q;
  logic signed [CW-1:0]  nx_c, ny_c;
  logic                  nb_in;

  // update arithmetic
  logic signed [8:0]  diff_q;
  logic signed [26:0] p1_q;
  logic signed [35:0] p2_q;
  logic [33:0]        amtp_c;
  logic [8:0]         amt_c;
  logic signed [11:0] q1_c, fdelta_c, delta_c;
  logic [11:0]        qa_c;
  logic [25:0]        qp_c;
  logic [9:0]         q10_c;
  logic signed [12:0] hsum_c;
  logic [7:0]         hnew_c;

  // memory
  logic [7:0]           mem [DEPTH];
  logic [7:0]           rd_q;
  logic                 we, re;
  logic signed [CW-1:0] ram_x, ram_y;
  logic [AW-1:0]        addr;

  // divider
  logic            div_start, div_done;
  logic [NUMW-1:0] div_num, div_quot;
  logic [DENW-1:0] div_den;

  logic       out_valid_q, oom_q;
  logic [7:0] hout_q;

  assign item_in = in_map(CW'(cx_q), CW'(cy_q), cfg_i.eff_w, cfg_i.eff_h);
  assign r_eff   = ({1'b0, cfg_i.radius} > RADW'(MAX_RADIUS)) ? RADW'(MAX_RADIUS)
                                                              : {1'b0, cfg_i.radius};
  assign ii_c    = i_q * i_q;
  assign jj_c    = j_q * j_q;
  assign nx_c    = px_q + CW'(di_q);
  assign ny_c    = py_q + CW'(dj_q);
  assign nb_in   = in_map(nx_c, ny_c, cfg_i.eff_w, cfg_i.eff_h);

  always_ff @(posedge clk_i) begin
    case (op)
      OP_LOAD: begin
        func_q <= func_i;
        cx_q   <= pos_x_i;
        cy_q   <= pos_y_i;
        hin_q  <= height_in_i;
      end
      OP_BR_INIT: begin
        r_q  <= r_eff;
        i_q  <= -r_eff;
        j_q  <= -r_eff;
        r2_q <= R2W'(r_eff) * R2W'(r_eff);
      end
      OP_DEN1: rf_q  <= RFW'(r2_q) * RFW'(cfg_i.falloff);
      OP_DEN2: den_q <= DENW'(rf_q) * DENW'(250) + DENW'(32);
      OP_CHK: begin
        d2_q <= D2W'(ii_c) + D2W'(jj_c);
        px_q <= CW'(cx_q) + CW'(i_q);
        py_q <= CW'(cy_q) + CW'(j_q);
      end
      OP_NUM:  num_q <= NUMW'(d2_q) * NUMW'(XQ_SCALE);
      OP_EXP1: begin
        big_q <= |div_quot[NUMW-1:20];
        y_q   <= yprod_c[36:16];
      end
      OP_EXP2: begin
        k_q  <= y_q[20:16];
        tn_q <= tn_c;
        ip_q <= iprod_c[23:12];
      end
      OP_EXP3: w_q <= (big_q || k_q >= 5'd17) ? '0 : (m_c >> k_q);
      OP_CAPH: h_q <= rd_q;
      OP_NB_INIT: begin
        di_q   <= -SH;
        dj_q   <= -SH;
        pend_q <= 1'b0;
        sum_q  <= '0;
        cnt_q  <= '0;
      end
      OP_NB, OP_NB_ACC: begin
        if (pend_q) begin
          sum_q <= sum_q + SUMW'(rd_q);
          cnt_q <= cnt_q + 1'b1;
        end
        pend_q <= (op == OP_NB) && nb_in;
        if (op == OP_NB) begin
          if (dj_q == SH) begin
            dj_q <= -SH;
            di_q <= di_q + 4'sd1;
          end else begin
            dj_q <= dj_q + 4'sd1;
          end
        end
      end
      OP_DIFF: begin
        case (cfg_i.mode)
          MODE_SMOOTH:  diff_q <= 9'(div_quot[7:0]) - 9'(h_q);
          MODE_FLATTEN: diff_q <= 9'd128 - 9'(h_q);
          default:      diff_q <= 9'sd1;
        endcase
      end
      OP_MUL1: p1_q <= diff_q * $signed({1'b0, w_q});
      OP_MUL2: p2_q <= p1_q * $signed({1'b0, cfg_i.strength});
      OP_ADV: begin
        if (j_q == r_q) begin
          j_q <= -r_q;
          i_q <= i_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // falloff weight: 2^-y with y = xq * log2(e), interpolated table
  assign yprod_c = 37'(div_quot[19:0]) * 37'(LOG2E_Q16);
  assign tn_c    = pow2_frac({1'b0, y_q[15:12]});
  assign tn1_c   = pow2_frac({1'b0, y_q[15:12]} + 5'd1);
  assign dlt_c   = 12'(tn_c - tn1_c);
  assign iprod_c = 24'(dlt_c) * 24'(y_q[11:0]);
  assign m_c     = tn_q - 17'(ip_q);

  // height update
  assign amtp_c   = 34'(p2_q[25:0]) * 34'd255;
  assign amt_c    = amtp_c[33:25];
  assign q1_c     = p2_q[35:24];
  assign qa_c     = q1_c[11] ? (12'(-q1_c) + 12'd9) : 12'(q1_c);
  assign qp_c     = 26'(qa_c) * 26'd6554;
  assign q10_c    = qp_c[25:16];
  assign fdelta_c = q1_c[11] ? -$signed({2'b00, q10_c}) : $signed({2'b00, q10_c});

  always_comb begin
    case (cfg_i.mode)
      MODE_RAISE:   delta_c = $signed({3'b000, amt_c});
      MODE_LOWER:   delta_c = -$signed({3'b000, amt_c});
      MODE_SMOOTH:  delta_c = q1_c;
      default:      delta_c = fdelta_c;
    endcase
  end

  assign hsum_c = $signed({5'b00000, h_q}) + 13'(delta_c);
  assign hnew_c = hsum_c[12] ? 8'd0 : ((hsum_c > 13'sd255) ? 8'd255 : hsum_c[7:0]);

  // single port store
  always_comb begin
    ram_x = px_q;
    ram_y = py_q;
    case (op)
      OP_RW: begin
        ram_x = CW'(cx_q);
        ram_y = CW'(cy_q);
      end
      OP_NB: begin
        ram_x = nx_c;
        ram_y = ny_c;
      end
      default: ;
    endcase
  end

  assign addr = AW'($unsigned(ram_y)) * AW'(MAX_WIDTH) + AW'($unsigned(ram_x));
  assign we   = ((op == OP_RW) && (func_q == FUNC_WRITE) && item_in) || (op == OP_WB);
  assign re   = ((op == OP_RW) && (func_q == FUNC_READ) && item_in) || (op == OP_RDH)
                || ((op == OP_NB) && nb_in);

  always_ff @(posedge clk_i) begin
    if (we) mem[addr] <= (op == OP_WB) ? hnew_c : hin_q;
    if (re) rd_q <= mem[addr];
  end

  assign div_start = (op == OP_DIVW) || (op == OP_DIVA);
  assign div_num   = (op == OP_DIVA) ? NUMW'(sum_q) : num_q;
  assign div_den   = (op == OP_DIVA) ? DENW'(cnt_q) : den_q;

  hbs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op == OP_FIN) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op == OP_FIN) begin
      hout_q <= ((func_q == FUNC_READ) && item_in) ? rd_q : 8'd0;
      oom_q  <= ((func_q == FUNC_READ) || (func_q == FUNC_WRITE)) && !item_in;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign height_out_o = hout_q;
  assign out_of_map_o = oom_q;

  assign stat_o.func     = func_q;
  assign stat_o.skip     = ({1'b0, d2_q} > (D2W + 1)'(r2_q))
                           || !in_map(px_q, py_q, cfg_i.eff_w, cfg_i.eff_h)
                           || (cfg_i.mode >= MODE_NONE);
  assign stat_o.at_last  = (i_q == r_q) && (j_q == r_q);
  assign stat_o.nb_last  = (di_q == SH) && (dj_q == SH);
  assign stat_o.div_done = div_done;
  assign stat_o.smooth   = cfg_i.mode == MODE_SMOOTH;
  assign stat_o.out_full = out_valid_q && !out_ready_i;

endmodule

### design/heightmap_brush_sculpt_core.sv
// Heightmap sculpting core: write, read or brush-stamp an 8-bit height store.
// A brush walks every offset of its square; each visited cell runs the weight divider and,
// when smoothing, a window read of (2*SMOOTH_HALF+1)^2 cells and an averaging divide.
// One item at a time; the next request is taken once the current one has finished.
// Reset clears controller and result valid and restores registers; store not cleared.
module heightmap_brush_sculpt_core #(
  parameter int MAX_WIDTH   = 512,
  parameter int MAX_HEIGHT  = 512,
  parameter int MAX_RADIUS  = 50,
  parameter int SMOOTH_HALF = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [9:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         func_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [7:0]         height_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         height_out_o,
  output logic               out_of_map_o
);
  import hbs_pkg::*;

  logic [5:0] radius_q;
  logic [8:0] strength_q;
  logic [8:0] falloff_q;
  logic [2:0] mode_q;
  logic [9:0] map_w_q;
  logic [9:0] map_h_q;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  // register file; writes must only arrive while idle, which the block does not enforce
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= 6'd10;
      strength_q <= 9'd128;
      falloff_q  <= 9'd128;
      mode_q     <= MODE_RAISE;
      map_w_q    <= 10'd512;
      map_h_q    <= 10'd512;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RADIUS:   radius_q   <= cfg_wdata_i[5:0];
        CFG_STRENGTH: strength_q <= cfg_wdata_i[8:0];
        CFG_FALLOFF:  falloff_q  <= cfg_wdata_i[8:0];
        CFG_MODE:     mode_q     <= cfg_wdata_i[2:0];
        CFG_WIDTH:    map_w_q    <= cfg_wdata_i;
        CFG_HEIGHT:   map_h_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clamp the map in use to the physical store
  always_comb begin
    cfg.radius   = radius_q;
    cfg.strength = strength_q;
    cfg.falloff  = falloff_q;
    cfg.mode     = mode_q;
    cfg.eff_w    = (EW'(map_w_q) < EW'(MAX_WIDTH)) ? EW'(map_w_q) : EW'(MAX_WIDTH);
    cfg.eff_h    = (EW'(map_h_q) < EW'(MAX_HEIGHT)) ? EW'(map_h_q) : EW'(MAX_HEIGHT);
  end

  hbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hbs_datapath #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_RADIUS  (MAX_RADIUS),
    .SMOOTH_HALF (SMOOTH_HALF)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_i        (cfg),
    .func_i       (func_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .height_in_i  (height_in_i),
    .out_ready_i  (out_ready_i),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .height_out_o (height_out_o),
    .out_of_map_o (out_of_map_o)
  );

  assign in_ready_o = cmd.in_ready;

endmodule

### design/hbs_checker.sv
module hbs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [2:0]         cfg_idx_i,
  input logic [9:0]         cfg_wdata_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         func_i,
  input logic signed [15:0] pos_x_i,
  input logic signed [15:0] pos_y_i,
  input logic [7:0]         height_in_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [7:0]         height_out_o,
  input logic               out_of_map_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  a_oom_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_map_o |-> height_out_o == 8'd0)
    else $error("out-of-map result carries a height");

  // a reset edge leaves no result valid
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind heightmap_brush_sculpt_core hbs_checker u_hbs_checker (.*);
